FILE: rtl/icmr_pkg.sv
// ----------------------------------------------------------------------------
// icmr_pkg
// Shared types and constants of the int8 convolution MAC / requantize unit.
// ----------------------------------------------------------------------------
package icmr_pkg;

   localparam int BIAS_SHIFT_DEFAULT = 8;
   localparam int CH_SHIFT_MAX       = 63;
   localparam int QUEUE_DEPTH        = 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_ZERO_POINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRELU_ENABLE     = 2'd2;

   typedef struct packed {
      logic signed [15:0] product;
      logic               last_term;
      logic signed [47:0] channel_bias;
      logic signed [31:0] channel_mult;
      logic [5:0]         channel_shift;
      logic signed [31:0] leak_mult;
      logic [5:0]         leak_shift;
   } entry_type;

   typedef struct packed {
      logic signed [7:0] output_offset;
      logic              prelu_enable;
   } back_cfg_type;

endpackage

FILE: rtl/icmr_front.sv
// ----------------------------------------------------------------------------
// icmr_front
// Input stage: pad substitution, 8x8 signed product, beat packing.
// ----------------------------------------------------------------------------
module icmr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [7:0]      req_activation,
   input  logic signed [7:0]      req_weight,
   input  logic                   req_is_pad,
   input  logic                   req_last_term,
   input  logic signed [47:0]     req_channel_bias,
   input  logic signed [31:0]     req_channel_mult,
   input  logic [5:0]             req_channel_shift,
   input  logic signed [31:0]     req_leak_mult,
   input  logic [5:0]             req_leak_shift,
   input  logic signed [7:0]      input_zero_point,
   output logic                   push_valid,
   input  logic                   push_ready,
   output icmr_pkg::entry_type    push_entry
);

   logic                valid_ff, valid_in;
   icmr_pkg::entry_type entry_ff, entry_in;
   logic                accept;
   logic signed [7:0]   act;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      act = req_is_pad ? 8'(8'sd0 - input_zero_point) : req_activation;
      entry_in.product       = 16'(act) * 16'(req_weight);
      entry_in.last_term     = req_last_term;
      entry_in.channel_bias  = req_channel_bias;
      entry_in.channel_mult  = req_channel_mult;
      entry_in.channel_shift = req_channel_shift;
      entry_in.leak_mult     = req_leak_mult;
      entry_in.leak_shift    = req_leak_shift;
      valid_in = accept || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: rtl/icmr_queue.sv
// ----------------------------------------------------------------------------
// icmr_queue
// Short FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module icmr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  icmr_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output icmr_pkg::entry_type pop_entry
);

   localparam int DEPTH = icmr_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   icmr_pkg::entry_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/icmr_back.sv
// ----------------------------------------------------------------------------
// icmr_back
// Accumulator and requantize sequencer: bias, optional PReLU scaling,
// channel scaling through a shared 32x32 multiplier, rounding shifts, clamp.
// ----------------------------------------------------------------------------
module icmr_back #(
   parameter int BIAS_SHIFT = icmr_pkg::BIAS_SHIFT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  icmr_pkg::back_cfg_type cfg,
   input  logic                   pop_valid,
   output logic                   pop,
   input  icmr_pkg::entry_type    pop_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [7:0]      rsp_out_value
);

   localparam int TSH_W = $clog2(icmr_pkg::CH_SHIFT_MAX + BIAS_SHIFT + 1);

   localparam logic [2:0] ST_ACC  = 3'd0;
   localparam logic [2:0] ST_BIAS = 3'd1;
   localparam logic [2:0] ST_MLO  = 3'd2;
   localparam logic [2:0] ST_MHI  = 3'd3;
   localparam logic [2:0] ST_MCMB = 3'd4;
   localparam logic [2:0] ST_RADD = 3'd5;
   localparam logic [2:0] ST_RSHF = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]   state_ff, state_in;
   logic [31:0]  acc_ff, acc_in;
   logic [31:0]  sum_ff, sum_in;
   logic         leak_ph_ff, leak_ph_in;
   logic [63:0]  work_ff, work_in;
   logic [63:0]  mlo_ff, mlo_in;
   logic [31:0]  mhi_ff, mhi_in;
   logic [63:0]  mres_ff, mres_in;
   logic [63:0]  rs_ff, rs_in;
   logic [63:0]  q_ff, q_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_value_ff, rsp_value_in;
   logic [47:0]  bias_ff;
   logic [31:0]  cmult_ff, lmult_ff;
   logic [5:0]   cshift_ff, lshift_ff;

   logic         take_last;
   logic         out_load;
   logic [31:0]  mul_a, mul_m;
   logic [63:0]  mul_p;
   logic [TSH_W-1:0] sh;
   logic [31:0]  sh_wide;
   logic [63:0]  half;
   logic [63:0]  shifted;
   logic [31:0]  hi_word;
   logic [31:0]  prod_ext;

   assign pop           = pop_valid && (state_ff == ST_ACC);
   assign take_last     = pop && pop_entry.last_term;
   assign out_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;

   assign mul_m = leak_ph_ff ? lmult_ff : cmult_ff;
   assign mul_a = (state_ff == ST_MLO) ? work_ff[31:0] : work_ff[63:32];
   assign mul_p = {32'b0, mul_a} * {32'b0, mul_m};

   always_comb begin
      sh = leak_ph_ff ? TSH_W'(lshift_ff) : TSH_W'(cshift_ff) + TSH_W'(BIAS_SHIFT);
      sh_wide = 32'(sh);
      if (sh_wide == 32'd0 || sh_wide > 32'd64) begin
         half = '0;
      end else begin
         half = 64'd1 << (sh_wide - 32'd1);
      end
      if (sh_wide >= 32'd64) begin
         shifted = '0;
      end else begin
         shifted = 64'($signed(rs_ff) >>> sh_wide);
      end
      hi_word  = mhi_ff - (mul_m[31] ? work_ff[31:0] : 32'd0);
      prod_ext = 32'(pop_entry.product);
   end

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      leak_ph_in = leak_ph_ff;
      work_in    = work_ff;
      mlo_in     = mlo_ff;
      mhi_in     = mhi_ff;
      mres_in    = mres_ff;
      rs_in      = rs_ff;
      q_in       = q_ff;
      unique case (state_ff)
         ST_ACC: begin
            if (pop) begin
               if (pop_entry.last_term) begin
                  sum_in   = acc_ff + prod_ext;
                  acc_in   = '0;
                  state_in = ST_BIAS;
               end else begin
                  acc_in = acc_ff + prod_ext;
               end
            end
         end
         ST_BIAS: begin
            work_in = ({{32{sum_ff[31]}}, sum_ff} << BIAS_SHIFT)
                      + {{16{bias_ff[47]}}, bias_ff};
            leak_ph_in = cfg.prelu_enable && work_in[63];
            state_in   = ST_MLO;
         end
         ST_MLO: begin
            mlo_in   = mul_p;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            mhi_in   = mul_p[31:0];
            state_in = ST_MCMB;
         end
         ST_MCMB: begin
            mres_in  = mlo_ff + {hi_word, 32'b0};
            state_in = ST_RADD;
         end
         ST_RADD: begin
            rs_in    = (sh_wide == 32'd0) ? mres_ff : mres_ff + half;
            state_in = ST_RSHF;
         end
         ST_RSHF: begin
            if (leak_ph_ff) begin
               work_in    = (sh_wide == 32'd0) ? rs_ff : shifted;
               leak_ph_in = 1'b0;
               state_in   = ST_MLO;
            end else begin
               q_in     = ((sh_wide == 32'd0) ? rs_ff : shifted)
                          + {{56{cfg.output_offset[7]}}, cfg.output_offset};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_comb begin
      if ($signed(q_ff) < -64'sd128) begin
         rsp_value_in = 8'h80;
      end else if ($signed(q_ff) > 64'sd127) begin
         rsp_value_in = 8'h7F;
      end else begin
         rsp_value_in = q_ff[7:0];
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         acc_ff       <= '0;
         leak_ph_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         leak_ph_ff   <= leak_ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff  <= sum_in;
      work_ff <= work_in;
      mlo_ff  <= mlo_in;
      mhi_ff  <= mhi_in;
      mres_ff <= mres_in;
      rs_ff   <= rs_in;
      q_ff    <= q_in;
      if (out_load) begin
         rsp_value_ff <= rsp_value_in;
      end
      if (take_last) begin
         bias_ff   <= pop_entry.channel_bias;
         cmult_ff  <= pop_entry.channel_mult;
         cshift_ff <= pop_entry.channel_shift;
         lmult_ff  <= pop_entry.leak_mult;
         lshift_ff <= pop_entry.leak_shift;
      end
   end

   a_acc_clears: assert property (@(posedge clock) disable iff (reset)
      take_last |=> acc_ff == 32'd0)
      else $error("accumulator not cleared after last term");

   a_stay_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !take_last) |=> state_ff == ST_ACC)
      else $error("sequencer left accumulate without a last term");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output step");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACC) |-> !pop)
      else $error("queue popped while sequencer busy");

endmodule

FILE: rtl/int8_conv_mac_requantize_unit.sv
// ----------------------------------------------------------------------------
// int8_conv_mac_requantize_unit
// Int8 convolution multiply-accumulate with per-channel requantization.
//
// Request channel (req_*): one beat per multiply term, valid/stall handshake.
// A beat with req_last_term closes one output value; the channel fields are
// used only on that beat. Response channel (rsp_*): one beat per closed value
// carrying the clamped int8 result. CSR port: write-only, index 0 input zero
// point, 1 output offset, 2 PReLU enable; write only while the unit is idle.
//
// Throughput: one non-last term per cycle while the back end is accumulating.
// A last term holds the back-end sequencer through its steps, and longer when
// the PReLU pass runs, since each 64x32 product takes a low and a high pass
// through one shared 32x32 multiplier. A two-entry queue lets the front keep
// taking terms meanwhile. A last term goes through the front register, the
// queue and the sequencer steps before rsp_valid rises.
// Reset (synchronous) clears the accumulator, the queue, the CSRs and the
// response valid flag. While rsp_stall is high the result beat holds and the
// queue and front stage fill, after which req_stall rises.
// ----------------------------------------------------------------------------
module int8_conv_mac_requantize_unit #(
   parameter int BIAS_SHIFT = icmr_pkg::BIAS_SHIFT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [7:0]              req_activation,
   input  logic signed [7:0]              req_weight,
   input  logic                           req_is_pad,
   input  logic                           req_last_term,
   input  logic signed [47:0]             req_channel_bias,
   input  logic signed [31:0]             req_channel_mult,
   input  logic [5:0]                     req_channel_shift,
   input  logic signed [31:0]             req_leak_mult,
   input  logic [5:0]                     req_leak_shift,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [7:0]              rsp_out_value,
   input  logic                           csr_write,
   input  logic [icmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);

   logic signed [7:0]      izp_ff, izp_in;
   logic signed [7:0]      ofs_ff, ofs_in;
   logic                   prelu_ff, prelu_in;
   icmr_pkg::back_cfg_type back_cfg;
   icmr_pkg::entry_type    push_entry, pop_entry;
   logic                   push_valid, push_ready, pop_valid, pop;

   always_comb begin
      izp_in   = izp_ff;
      ofs_in   = ofs_ff;
      prelu_in = prelu_ff;
      if (csr_write) begin
         unique case (csr_index)
            icmr_pkg::CSR_INPUT_ZERO_POINT: izp_in   = csr_wdata;
            icmr_pkg::CSR_OUTPUT_OFFSET:    ofs_in   = csr_wdata;
            icmr_pkg::CSR_PRELU_ENABLE:     prelu_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         izp_ff   <= '0;
         ofs_ff   <= '0;
         prelu_ff <= 1'b0;
      end else begin
         izp_ff   <= izp_in;
         ofs_ff   <= ofs_in;
         prelu_ff <= prelu_in;
      end
   end

   assign back_cfg.output_offset = ofs_ff;
   assign back_cfg.prelu_enable  = prelu_ff;

   icmr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_activation    (req_activation),
      .req_weight        (req_weight),
      .req_is_pad        (req_is_pad),
      .req_last_term     (req_last_term),
      .req_channel_bias  (req_channel_bias),
      .req_channel_mult  (req_channel_mult),
      .req_channel_shift (req_channel_shift),
      .req_leak_mult     (req_leak_mult),
      .req_leak_shift    (req_leak_shift),
      .input_zero_point  (izp_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   icmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   icmr_back #(
      .BIAS_SHIFT (BIAS_SHIFT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (back_cfg),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value)
   );

endmodule

FILE: verif/tb_int8_conv_mac_requantize_unit.sv
// ----------------------------------------------------------------------------
// tb_int8_conv_mac_requantize_unit
// Self-checking bench for the int8 convolution MAC / requantize unit.
//
// A queue of multiply terms feeds a clocked driver. Every accepted term goes
// through a bit-accurate model of the accumulator and the requantize path.
// Each closing term yields one expected int8 value, and a clocked monitor
// checks it against the response beats. Both channels idle and stall at
// random. The CSRs change between phases only after the unit has drained.
// The run covers directed corner terms, a long back-to-back run at the
// largest product, and random output values under several CSR settings.
// ----------------------------------------------------------------------------
module tb_int8_conv_mac_requantize_unit;

   localparam int BIAS_SHIFT     = icmr_pkg::BIAS_SHIFT_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int LONG_TERMS     = 200;
   localparam int PHASE_TERMS    = 200;

   typedef struct {
      logic signed [7:0]  activation;
      logic signed [7:0]  weight;
      logic               is_pad;
      logic               last_term;
      logic signed [47:0] channel_bias;
      logic signed [31:0] channel_mult;
      logic [5:0]         channel_shift;
      logic signed [31:0] leak_mult;
      logic [5:0]         leak_shift;
   } conv_term_type;

   logic                           clock;
   logic                           reset             = 1'b1;
   logic                           req_valid         = 1'b0;
   logic                           req_stall;
   logic signed [7:0]              req_activation    = '0;
   logic signed [7:0]              req_weight        = '0;
   logic                           req_is_pad        = 1'b0;
   logic                           req_last_term     = 1'b0;
   logic signed [47:0]             req_channel_bias  = '0;
   logic signed [31:0]             req_channel_mult  = '0;
   logic [5:0]                     req_channel_shift = '0;
   logic signed [31:0]             req_leak_mult     = '0;
   logic [5:0]                     req_leak_shift    = '0;
   logic                           rsp_valid;
   logic                           rsp_stall         = 1'b0;
   logic signed [7:0]              rsp_out_value;
   logic                           csr_write         = 1'b0;
   logic [icmr_pkg::CSR_IDX_W-1:0] csr_index         = icmr_pkg::CSR_INPUT_ZERO_POINT;
   logic [7:0]                     csr_wdata         = '0;

   // shadow of the unit's CSRs and accumulator
   logic signed [7:0]  zero_point = '0;
   logic signed [7:0]  out_offset = '0;
   bit                 prelu_on   = 1'b0;
   logic signed [31:0] mac_total  = '0;

   conv_term_type     pending_terms[$];
   logic signed [7:0] expected_outputs[$];
   conv_term_type     driven_term;
   int                issued_terms   = 0;
   int                accepted_terms = 0;
   int                mismatch_count = 0;
   int                send_gap       = 0;
   int                stall_left     = 0;
   bit                send_quiet     = 1'b0;
   bit                recv_quiet     = 1'b0;
   bit                send_burst     = 1'b0;

   int8_conv_mac_requantize_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 39) == 0)
         quiet = ~quiet;
      return quiet ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
      if (s == 0)
         return v;
      if (s >= 64)
         return '0;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [7:0] requantize(logic signed [31:0] sum,
                                                    conv_term_type t);
      logic signed [63:0] work;
      logic signed [63:0] bias64;
      logic signed [63:0] mult64;
      logic signed [63:0] leak64;
      logic signed [63:0] offset64;
      logic signed [63:0] q;
      work     = 64'(sum);
      bias64   = 64'(t.channel_bias);
      mult64   = 64'(t.channel_mult);
      leak64   = 64'(t.leak_mult);
      offset64 = 64'(out_offset);
      work     = (work <<< BIAS_SHIFT) + bias64;
      if (prelu_on && work < 0)
         work = round_shift(work * leak64, int'(t.leak_shift));
      q = round_shift(work * mult64, int'(t.channel_shift) + BIAS_SHIFT) + offset64;
      if (q < -128)
         return -8'sd128;
      if (q > 127)
         return 8'sd127;
      return q[7:0];
   endfunction

   task automatic accumulate_term(conv_term_type t);
      logic signed [7:0]  act;
      logic signed [15:0] prod;
      act       = t.is_pad ? -zero_point : t.activation;
      prod      = 16'(act) * 16'(t.weight);
      mac_total = mac_total + 32'(prod);
      if (t.last_term) begin
         expected_outputs.push_back(requantize(mac_total, t));
         mac_total = '0;
      end
   endtask

   function automatic conv_term_type make_term(logic signed [7:0] a, logic signed [7:0] w,
                                               bit pad, bit last, logic signed [47:0] bias,
                                               logic signed [31:0] mult, int cs,
                                               logic signed [31:0] lm, int ls);
      conv_term_type t;
      t.activation    = a;
      t.weight        = w;
      t.is_pad        = pad;
      t.last_term     = last;
      t.channel_bias  = bias;
      t.channel_mult  = mult;
      t.channel_shift = 6'(cs);
      t.leak_mult     = lm;
      t.leak_shift    = 6'(ls);
      return t;
   endfunction

   function automatic conv_term_type random_term(bit last);
      conv_term_type t;
      int            r;
      t.activation = 8'($urandom);
      t.weight     = 8'($urandom);
      t.is_pad     = ($urandom_range(0, 7) == 0);
      t.last_term  = last;
      if ($urandom_range(0, 1)) begin
         r               = $urandom;
         t.channel_bias  = 48'(r >>> 10);
         t.channel_mult  = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
         t.channel_shift = 6'($urandom_range(30, 46));
         t.leak_mult     = $urandom_range(0, 32'h7FFF_FFFF);
         t.leak_shift    = 6'($urandom_range(29, 33));
      end else begin
         t.channel_bias  = 48'({$urandom, $urandom});
         t.channel_mult  = $urandom;
         t.channel_shift = 6'($urandom_range(0, 47));
         t.leak_mult     = $urandom;
         t.leak_shift    = 6'($urandom_range(0, 47));
      end
      return t;
   endfunction

   function automatic logic [7:0] pick_int8();
      case ($urandom_range(0, 3))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_term(conv_term_type t);
      pending_terms.push_back(t);
      issued_terms++;
   endtask

   task automatic write_csr(logic [icmr_pkg::CSR_IDX_W-1:0] idx, logic [7:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         icmr_pkg::CSR_INPUT_ZERO_POINT: zero_point = data;
         icmr_pkg::CSR_OUTPUT_OFFSET:    out_offset = data;
         icmr_pkg::CSR_PRELU_ENABLE:     prelu_on   = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] zp, logic [7:0] off, bit prelu);
      write_csr(icmr_pkg::CSR_INPUT_ZERO_POINT, zp);
      write_csr(icmr_pkg::CSR_OUTPUT_OFFSET, off);
      write_csr(icmr_pkg::CSR_PRELU_ENABLE, {7'd0, prelu});
   endtask

   // terms that close no value leave no trace, so pause for the pipe to empty
   task automatic wait_drained();
      while (accepted_terms != issued_terms || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      bit next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_term(driven_term);
            accepted_terms++;
         end
         if (!(req_valid && req_stall)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_terms.size() != 0) begin
               driven_term       = pending_terms.pop_front();
               next_valid        = 1'b1;
               send_gap          = send_burst ? 0 : draw_wait(send_quiet);
               req_activation    <= driven_term.activation;
               req_weight        <= driven_term.weight;
               req_is_pad        <= driven_term.is_pad;
               req_last_term     <= driven_term.last_term;
               req_channel_bias  <= driven_term.channel_bias;
               req_channel_mult  <= driven_term.channel_mult;
               req_channel_shift <= driven_term.channel_shift;
               req_leak_mult     <= driven_term.leak_mult;
               req_leak_shift    <= driven_term.leak_shift;
            end
            req_valid <= next_valid;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic signed [7:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected beat, out_value expected none, got %0d",
                        $time, rsp_out_value);
               mismatch_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_out_value !== want) begin
                  $display("%0t: out_value expected %0d, got %0d",
                           $time, want, rsp_out_value);
                  mismatch_count++;
               end
            end
            stall_left = draw_wait(recv_quiet);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int n;
      int count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset CSRs; channel fields on open terms must be ignored
      queue_term(make_term(-128, -128, 0, 0, 48'h8000_0000_0001, 32'h8000_0001, 63,
                           32'h7FFF_FFFF, 63));
      queue_term(make_term(127, 127, 0, 0, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 0,
                           32'h8000_0000, 0));
      queue_term(make_term(-128, 127, 0, 1, 0, 32'h4000_0000, 20, 0, 0));
      queue_term(make_term(5, -3, 0, 1, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 47, 0, 0));
      queue_term(make_term(0, 0, 0, 1, 48'h8000_0000_0000, 32'h8000_0000, 0, 0, 0));
      queue_term(make_term(77, 1, 1, 1, 48'h100, 32'h7FFF_FFFF, 0, 0, 0));
      queue_term(make_term(-1, 1, 0, 1, 0, -1, 0, 0, 0));
      queue_term(make_term(10, 10, 0, 1, 0, 32'h4000_0000, 30, 0, 0));
      // exact halves round up
      queue_term(make_term(1, 1, 0, 1, 0, 1, 1, 0, 0));
      queue_term(make_term(-1, 1, 0, 1, 0, 1, 1, 0, 0));
      wait_drained();

      // zero point -128: pad activation wraps to -128
      set_config(8'h80, 8'h7F, 1'b1);
      queue_term(make_term(3, 127, 1, 0, 0, 0, 0, 0, 0));
      queue_term(make_term(0, -128, 1, 1, 0, 32'h4000_0000, 30, 0, 0));
      queue_term(make_term(-100, 50, 0, 1, 0, 32'h4000_0000, 30, 32'h4000_0000, 31));
      queue_term(make_term(-1, 1, 0, 1, 0, 32'h4000_0000, 30, 3, 0));
      queue_term(make_term(-1, 1, 0, 1, 0, 32'h7FFF_FFFF, 47, 32'h7FFF_FFFF, 47));
      queue_term(make_term(-128, 127, 0, 1, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 47));
      wait_drained();

      set_config(8'h7F, 8'h80, 1'b1);
      queue_term(make_term(5, 127, 1, 1, 0, 32'h8000_0000, 47, 0, 0));
      queue_term(make_term(127, -128, 0, 1, 48'h8000_0000_0000, 32'h4000_0000, 12, -1, 1));
      wait_drained();

      // long back-to-back run at the largest product
      set_config(pick_int8(), pick_int8(), 1'($urandom_range(0, 1)));
      send_burst = 1'b1;
      for (int i = 0; i < LONG_TERMS; i++)
         queue_term(make_term(-128, -128, 0, i == LONG_TERMS - 1, 0, 32'h4000_0000, 40,
                              32'h4000_0000, 31));
      wait_drained();
      send_burst = 1'b0;

      for (int p = 0; p < 8; p++) begin
         set_config(pick_int8(), pick_int8(), 1'($urandom_range(0, 1)));
         count = 0;
         while (count < PHASE_TERMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            for (int k = 1; k <= n; k++)
               queue_term(random_term(k == n));
            count += n;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && expected_outputs.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
